// File: sv/prime_field_alu_top_macros.svh
// ---------------------------------------------------------------------------
// prime_field_alu_top_macros
// assertion macros for the prime field alu, empty when SYNTH is set
// ---------------------------------------------------------------------------
`ifndef PRIME_FIELD_ALU_TOP_MACROS_SVH
`define PRIME_FIELD_ALU_TOP_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during rst
`define PFA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, sampled on clk, off during rst
`define PFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PFA_ASSERT_NOW(label, ante, cons, msg)
`define PFA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: sv/pfa_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfa_pkg
// shared types and constants of the prime field alu
// ---------------------------------------------------------------------------
package pfa_pkg;

  localparam int WORD_BITS_DEF = 8;
  localparam int CMD_BITS      = 3;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_INV = 3'd4,
    CMD_NEG = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED_A,
    S_RED_B,
    S_MUL,
    S_INV
  } state_t;

  // status of the inverse search unit
  typedef struct packed {
    logic done;
    logic found;
  } inv_stat_t;

endpackage

// File: sv/pfa_serial_mul.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfa_serial_mul
// bit-serial modular multiplier, one multiplier bit per cycle, msb first
// ---------------------------------------------------------------------------
module pfa_serial_mul import pfa_pkg::*; #(
  parameter int W = WORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [W-1:0] mcand,    // must be below modulus
  input  logic [W-1:0] mplier,
  input  logic [W-1:0] modulus,
  output logic         done,
  output logic [W-1:0] prod
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  acc;
  logic [W-1:0]  shreg;
  logic [W-1:0]  mc;
  logic [CW-1:0] cnt;
  logic          run;

  logic [W:0] dbl;
  logic [W:0] dbl_red;
  logic [W:0] sum;
  logic [W:0] sum_red;

  // acc = (2*acc + bit*mc) mod p, two compare-subtract steps
  always_comb begin
    dbl     = {acc, 1'b0};
    dbl_red = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
    sum     = {1'b0, dbl_red[W-1:0]} + (shreg[W-1] ? {1'b0, mc} : '0);
    sum_red = (sum >= {1'b0, modulus}) ? sum - {1'b0, modulus} : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= CW'(W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      acc   <= '0;
      shreg <= mplier;
      mc    <= mcand;
    end else if (run) begin
      acc   <= sum_red[W-1:0];
      shreg <= {shreg[W-2:0], 1'b0};
    end
  end

  assign prod = acc;

endmodule

// File: sv/pfa_inv_search.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfa_inv_search
// serial inverse search, steps i by one and x*i mod p by x each cycle
// ---------------------------------------------------------------------------
module pfa_inv_search import pfa_pkg::*; #(
  parameter int W = WORD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [W-1:0] x,        // reduced operand, below modulus
  input  logic [W-1:0] modulus,  // at least two
  output inv_stat_t    stat,
  output logic [W-1:0] inv
);

  logic [W-1:0] idx;
  logic [W-1:0] acc;
  logic [W-1:0] xr;
  logic         run;

  logic [W:0] sum;
  logic [W:0] sum_red;

  always_comb begin
    sum     = {1'b0, acc} + {1'b0, xr};
    sum_red = (sum >= {1'b0, modulus}) ? sum - {1'b0, modulus} : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run        <= 1'b0;
      stat.done  <= 1'b0;
      stat.found <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      if (go) begin
        run <= 1'b1;
      end else if (run) begin
        if (acc == W'(1)) begin
          run        <= 1'b0;
          stat.done  <= 1'b1;
          stat.found <= 1'b1;
        end else if (idx == modulus - W'(1)) begin
          run        <= 1'b0;
          stat.done  <= 1'b1;
          stat.found <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      idx <= W'(1);
      acc <= x;
      xr  <= x;
    end else if (run) begin
      if (acc == W'(1)) begin
        inv <= idx;
      end else if (idx == modulus - W'(1)) begin
        inv <= '0;
      end else begin
        idx <= idx + W'(1);
        acc <= sum_red[W-1:0];
      end
    end
  end

endmodule

// File: sv/pfa_seq.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfa_seq
// command sequencer, operand holding and final add, subtract or negate step
// ---------------------------------------------------------------------------
module pfa_seq import pfa_pkg::*; #(
  parameter int W = WORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [CMD_BITS-1:0] command,
  input  logic [W-1:0]        operand_a,
  input  logic [W-1:0]        operand_b,
  input  logic [W-1:0]        modulus,
  output logic                busy,
  output logic                done,
  output logic [W-1:0]        result,
  output logic                no_inverse,
  output logic                mul_go,
  output logic [W-1:0]        mul_mcand,
  output logic [W-1:0]        mul_mplier,
  input  logic [W-1:0]        mul_prod,
  input  logic                mul_done,
  output logic                inv_go,
  output logic [W-1:0]        inv_x,
  input  inv_stat_t           inv_stat,
  input  logic [W-1:0]        inv_val
);

  state_t       state, state_next;
  cmd_t         cmd, cmd_next;
  logic [W-1:0] b_hold, b_hold_next;
  logic [W-1:0] ar, ar_next;
  logic         done_next;
  logic [W-1:0] result_next;
  logic         no_inverse_next;

  logic [W:0]   sum;
  logic [W:0]   sum_red;
  logic [W-1:0] diff;
  logic         trivial;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd        <= cmd_next;
    b_hold     <= b_hold_next;
    ar         <= ar_next;
    result     <= result_next;
    no_inverse <= no_inverse_next;
  end

  always_comb begin
    sum     = {1'b0, ar} + {1'b0, mul_prod};
    sum_red = (sum >= {1'b0, modulus}) ? sum - {1'b0, modulus} : sum;
    // wraps back into range when ar < b
    diff    = (ar < mul_prod) ? ar - mul_prod + modulus : ar - mul_prod;
    // no field, or a command code with no meaning
    trivial = (modulus < W'(2)) || (command > CMD_NEG);
  end

  always_comb begin
    state_next      = state;
    cmd_next        = cmd;
    b_hold_next     = b_hold;
    ar_next         = ar;
    done_next       = 1'b0;
    result_next     = result;
    no_inverse_next = no_inverse;
    mul_go          = 1'b0;
    mul_mcand       = W'(1);
    mul_mplier      = operand_a;
    inv_go          = 1'b0;
    inv_x           = mul_prod;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd_next    = cmd_t'(command);
          b_hold_next = operand_b;
          if (trivial) begin
            done_next       = 1'b1;
            result_next     = '0;
            no_inverse_next = (command == CMD_DIV || command == CMD_INV) &&
                              (modulus < W'(2));
          end else begin
            // reduce a as 1 * a mod p
            mul_go     = 1'b1;
            state_next = S_RED_A;
          end
        end
      end
      S_RED_A: begin
        if (mul_done) begin
          ar_next = mul_prod;
          unique case (cmd)
            CMD_INV: begin
              inv_go     = 1'b1;
              state_next = S_INV;
            end
            CMD_NEG: begin
              result_next     = (mul_prod == '0) ? '0 : modulus - mul_prod;
              no_inverse_next = 1'b0;
              done_next       = 1'b1;
              state_next      = S_IDLE;
            end
            default: begin
              mul_go     = 1'b1;
              mul_mplier = b_hold;
              state_next = S_RED_B;
            end
          endcase
        end
      end
      S_RED_B: begin
        if (mul_done) begin
          unique case (cmd)
            CMD_ADD: begin
              result_next     = sum_red[W-1:0];
              no_inverse_next = 1'b0;
              done_next       = 1'b1;
              state_next      = S_IDLE;
            end
            CMD_SUB: begin
              result_next     = diff;
              no_inverse_next = 1'b0;
              done_next       = 1'b1;
              state_next      = S_IDLE;
            end
            CMD_MUL: begin
              mul_go     = 1'b1;
              mul_mcand  = ar;
              mul_mplier = mul_prod;
              state_next = S_MUL;
            end
            CMD_DIV: begin
              inv_go     = 1'b1;
              state_next = S_INV;
            end
            default: begin
              result_next     = '0;
              no_inverse_next = 1'b0;
              done_next       = 1'b1;
              state_next      = S_IDLE;
            end
          endcase
        end
      end
      S_MUL: begin
        if (mul_done) begin
          result_next     = mul_prod;
          no_inverse_next = 1'b0;
          done_next       = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_INV: begin
        if (inv_stat.done) begin
          if (cmd == CMD_DIV && inv_stat.found) begin
            mul_go     = 1'b1;
            mul_mcand  = ar;
            mul_mplier = inv_val;
            state_next = S_MUL;
          end else begin
            result_next     = inv_stat.found ? inv_val : '0;
            no_inverse_next = !inv_stat.found;
            done_next       = 1'b1;
            state_next      = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// File: sv/prime_field_alu_top.sv
// work per command: an unused command or a modulus below 2 is answered from idle;
//   additive inverse reduces a; add and subtract reduce a and b; multiply also
//   multiplies them; inverse reduces a and searches; divide reduces both, finds 1/b, multiplies
// throughput: one transfer at a time, the next start is taken once busy drops
// rate is set by the bit-serial multiplier and the one-step inverse search
// rst (synchronous) returns the sequencer to idle and loads modulus 2
`timescale 1ns / 1ps
`include "prime_field_alu_top_macros.svh"
// ---------------------------------------------------------------------------
// prime_field_alu_top
// GF(p) arithmetic unit: add, subtract, multiply, divide and both inverses
// ---------------------------------------------------------------------------
module prime_field_alu_top import pfa_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // command side, transfer when start is high and busy is low
  input  logic                 start,
  output logic                 busy,
  input  logic [CMD_BITS-1:0]  command,
  input  logic [WORD_BITS-1:0] operand_a,
  input  logic [WORD_BITS-1:0] operand_b,
  // modulus register write
  input  logic                 modulus_we,
  input  logic [WORD_BITS-1:0] modulus_data,
  // result side, one-cycle strobe, no backpressure
  output logic                 done,
  output logic [WORD_BITS-1:0] result,
  output logic                 no_inverse
);

  // field modulus, to be written only while idle; the block itself does not enforce this
  logic [WORD_BITS-1:0] modulus_reg;

  // multiplier hookup
  logic                 mul_go;
  logic [WORD_BITS-1:0] mul_mcand;
  logic [WORD_BITS-1:0] mul_mplier;
  logic [WORD_BITS-1:0] mul_prod;
  logic                 mul_done;

  // inverse search hookup
  logic                 inv_go;
  logic [WORD_BITS-1:0] inv_x;
  inv_stat_t            inv_stat;
  logic [WORD_BITS-1:0] inv_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus_reg <= WORD_BITS'(2);
    end else if (modulus_we) begin
      modulus_reg <= modulus_data;
    end
  end

  // sequencer: reduces a, and b where needed, through the multiplier (as 1*x mod p), then
  // finishes add/sub/neg directly or hands off to multiply or search
  pfa_seq #(
    .W (WORD_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .command    (command),
    .operand_a  (operand_a),
    .operand_b  (operand_b),
    .modulus    (modulus_reg),
    .busy       (busy),
    .done       (done),
    .result     (result),
    .no_inverse (no_inverse),
    .mul_go     (mul_go),
    .mul_mcand  (mul_mcand),
    .mul_mplier (mul_mplier),
    .mul_prod   (mul_prod),
    .mul_done   (mul_done),
    .inv_go     (inv_go),
    .inv_x      (inv_x),
    .inv_stat   (inv_stat),
    .inv_val    (inv_val)
  );

  // shared modular multiplier, one bit of the multiplier per cycle
  pfa_serial_mul #(
    .W (WORD_BITS)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .go      (mul_go),
    .mcand   (mul_mcand),
    .mplier  (mul_mplier),
    .modulus (modulus_reg),
    .done    (mul_done),
    .prod    (mul_prod)
  );

  // inverse search, first i with x*i mod p == 1
  pfa_inv_search #(
    .W (WORD_BITS)
  ) u_inv (
    .clk     (clk),
    .rst     (rst),
    .go      (inv_go),
    .x       (inv_x),
    .modulus (modulus_reg),
    .stat    (inv_stat),
    .inv     (inv_val)
  );

  // results always land in range when a field exists
  `PFA_ASSERT_NOW(a_result_range, done && (modulus_reg >= WORD_BITS'(2)), result < modulus_reg, "result not reduced")
  // a missing inverse always reports zero
  `PFA_ASSERT_NOW(a_noinv_zero, done && no_inverse, result == '0, "no_inverse with nonzero result")
  // the sequencer is back in idle when the strobe fires
  `PFA_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while busy")
  // without a field the answer comes in the next cycle
  `PFA_ASSERT_NEXT(a_trivial_fast, start && !busy && (modulus_reg < WORD_BITS'(2)), done, "no-field item not answered at once")

endmodule
